// ----- design/rsr_pkg.sv -----
// ----------------------------------------------------------------------------
// rsr_pkg: shared constants for the replacement selection run unit
// Field widths of the record, result and configuration channels, and the
// default slot count.
// ----------------------------------------------------------------------------
package rsr_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 16;
    localparam int RUN_W     = 16;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

// ----- design/rsr_in_if.sv -----
// ----------------------------------------------------------------------------
// rsr_in_if: record request channel
// Valid/ready channel carrying one record key, tag and last-record mark.
// ----------------------------------------------------------------------------
interface rsr_in_if;

    logic                      valid;
    logic                      ready;
    logic [rsr_pkg::KEY_W-1:0] record_key;
    logic [rsr_pkg::TAG_W-1:0] record_tag;
    logic                      final_record;

    modport source (output valid, output record_key, output record_tag,
                    output final_record, input ready);
    modport sink   (input valid, input record_key, input record_tag,
                    input final_record, output ready);

endinterface

// ----- design/rsr_out_if.sv -----
// ----------------------------------------------------------------------------
// rsr_out_if: emitted record channel
// Valid/ready channel carrying one emitted key, tag, run number and end flag.
// ----------------------------------------------------------------------------
interface rsr_out_if;

    logic                      valid;
    logic                      ready;
    logic [rsr_pkg::KEY_W-1:0] out_key;
    logic [rsr_pkg::TAG_W-1:0] out_tag;
    logic [rsr_pkg::RUN_W-1:0] run_index;
    logic                      stream_done;

    modport source (output valid, output out_key, output out_tag,
                    output run_index, output stream_done, input ready);
    modport sink   (input valid, input out_key, input out_tag,
                    input run_index, input stream_done, output ready);

endinterface

// ----- design/rsr_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rsr_cfg_if: configuration write channel
// Valid/ready channel carrying the slot count register write data.
// ----------------------------------------------------------------------------
interface rsr_cfg_if;

    logic                      valid;
    logic                      ready;
    logic [rsr_pkg::CFG_W-1:0] slots_in_use;

    modport source (output valid, output slots_in_use, input ready);
    modport sink   (input valid, input slots_in_use, output ready);

endinterface

// ----- design/replacement_selection_runs_unit.sv -----
// ----------------------------------------------------------------------------
// replacement_selection_runs_unit: replacement selection run generator
// Fill records are written straight into the next free slot. A replacing
// record, and each drain result, passes prepare, a scan of all slots and
// emit before it is registered. No record is taken until the unit is idle
// again; the single key comparator scans the slots one per cycle.
// Reset clears control, occupancy, freeze bits, run number and the register
// (to 16); slot keys and tags are not reset.
// ----------------------------------------------------------------------------
module replacement_selection_runs_unit #(
    parameter int SLOTS = rsr_pkg::SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsr_cfg_if.sink    i_cfg,
    rsr_in_if.sink     i_rec,
    rsr_out_if.source  o_res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_SCAN, ST_EMIT} t_state;

    t_state                    r_state;
    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             r_best_idx;
    logic [rsr_pkg::KEY_W-1:0] r_best_key;
    logic [rsr_pkg::TAG_W-1:0] r_best_tag;
    logic                      r_have_best;
    logic                      r_drain;
    logic                      r_fin;
    logic [rsr_pkg::KEY_W-1:0] r_new_key;
    logic [rsr_pkg::TAG_W-1:0] r_new_tag;
    logic [rsr_pkg::KEY_W-1:0] r_keys [SLOTS];
    logic [rsr_pkg::TAG_W-1:0] r_tags [SLOTS];
    logic [SLOTS-1:0]          r_occ;
    logic [SLOTS-1:0]          r_frz;
    logic [CW-1:0]             r_fill;
    logic [rsr_pkg::RUN_W-1:0] r_run;
    logic [rsr_pkg::CFG_W-1:0] r_slots_in_use;
    logic                      r_out_valid;
    logic [rsr_pkg::KEY_W-1:0] r_out_key;
    logic [rsr_pkg::TAG_W-1:0] r_out_tag;
    logic [rsr_pkg::RUN_W-1:0] r_out_run;
    logic                      r_out_done;

    logic [CW-1:0]             eff_m;
    logic                      rec_fire;
    logic                      cfg_fire;
    logic                      filling;
    logic                      stuck;
    logic                      cand;
    logic                      better;
    logic                      emit_fire;
    logic [SLOTS-1:0]          best_mask;
    logic                      done;
    logic                      wr_en;
    logic [IW-1:0]             wr_addr;
    logic [rsr_pkg::KEY_W-1:0] wr_key;
    logic [rsr_pkg::TAG_W-1:0] wr_tag;

    always_comb begin
        if (r_slots_in_use == '0) begin
            eff_m = CW'(1);
        end else if (32'(r_slots_in_use) > 32'(SLOTS)) begin
            eff_m = CW'(SLOTS);
        end else begin
            eff_m = CW'(r_slots_in_use);
        end
    end

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign i_rec.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign rec_fire    = i_rec.valid && i_rec.ready;
    assign filling     = (r_fill < eff_m);

    assign stuck     = (|r_occ) && ((r_occ & ~r_frz) == '0);
    assign cand      = r_occ[r_idx] && !r_frz[r_idx];
    assign better    = cand && (!r_have_best || (r_keys[r_idx] < r_best_key));
    assign emit_fire = (r_state == ST_EMIT) && (!r_out_valid || o_res.ready);
    assign best_mask = SLOTS'(1) << r_best_idx;
    assign done      = r_drain && ((r_occ & ~best_mask) == '0);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best_idx;
        wr_key  = r_new_key;
        wr_tag  = r_new_tag;
        if (rec_fire && filling) begin
            wr_en   = 1'b1;
            wr_addr = r_fill[IW-1:0];
            wr_key  = i_rec.record_key;
            wr_tag  = i_rec.record_tag;
        end else if (emit_fire && !r_drain) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_keys[wr_addr] <= wr_key;
            r_tags[wr_addr] <= wr_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_idx          <= '0;
            r_best_idx     <= '0;
            r_have_best    <= 1'b0;
            r_drain        <= 1'b0;
            r_fin          <= 1'b0;
            r_occ          <= '0;
            r_frz          <= '0;
            r_fill         <= '0;
            r_run          <= '0;
            r_slots_in_use <= rsr_pkg::CFG_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && !emit_fire) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (cfg_fire) begin
                        r_slots_in_use <= i_cfg.slots_in_use;
                        r_occ          <= '0;
                        r_frz          <= '0;
                        r_fill         <= '0;
                        r_run          <= '0;
                    end else if (rec_fire) begin
                        r_new_key <= i_rec.record_key;
                        r_new_tag <= i_rec.record_tag;
                        r_fin     <= i_rec.final_record;
                        if (filling) begin
                            r_occ[r_fill[IW-1:0]] <= 1'b1;
                            r_frz[r_fill[IW-1:0]] <= 1'b0;
                            r_fill                <= r_fill + CW'(1);
                            r_drain               <= 1'b1;
                            if (i_rec.final_record) begin
                                r_state <= ST_PREP;
                            end
                        end else begin
                            r_drain <= 1'b0;
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    if (stuck) begin
                        r_run <= r_run + rsr_pkg::RUN_W'(1);
                        r_frz <= '0;
                    end
                    r_idx       <= '0;
                    r_have_best <= 1'b0;
                    r_state     <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (better) begin
                        r_have_best <= 1'b1;
                        r_best_idx  <= r_idx;
                        r_best_key  <= r_keys[r_idx];
                        r_best_tag  <= r_tags[r_idx];
                    end
                    if (r_idx == IW'(SLOTS - 1)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        r_out_valid <= 1'b1;
                        r_out_key   <= r_best_key;
                        r_out_tag   <= r_best_tag;
                        r_out_run   <= r_run;
                        r_out_done  <= done;
                        if (!r_drain) begin
                            r_frz[r_best_idx] <= (r_new_key < r_best_key);
                            r_drain           <= 1'b1;
                            r_state           <= r_fin ? ST_PREP : ST_IDLE;
                        end else if (done) begin
                            r_occ   <= '0;
                            r_frz   <= '0;
                            r_fill  <= '0;
                            r_run   <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_occ[r_best_idx] <= 1'b0;
                            r_frz[r_best_idx] <= 1'b0;
                            r_state           <= ST_PREP;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_key     = r_out_key;
    assign o_res.out_tag     = r_out_tag;
    assign o_res.run_index   = r_out_run;
    assign o_res.stream_done = r_out_done;

    a_frz_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frz & ~r_occ) == '0)
        else $error("frozen slot not occupied");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(SLOTS))
        else $error("fill count beyond slot count");

    a_emit_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_have_best)
        else $error("emit without a selected slot");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && done) |=> (r_occ == '0) && (r_fill == '0) && (r_run == '0))
        else $error("stream not cleared after drain");

    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_occ & ~r_frz) != '0))
        else $error("scan with no live slot");

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: replacement selection run unit testbench
// Feeds record streams under several slot counts, keeps its own copy of the
// slots, freeze bits and run number, and checks every emitted record, run
// number and end flag in order. Both sides idle at random; the receiver
// holds off once for a long stretch and the sender pauses between streams.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = rsr_pkg::SLOTS_DEF;
    localparam int SETTLE     = 2 * (SLOTS + 3);
    localparam int HOLD       = 300;
    localparam int STALL_MAX  = 2000;
    localparam int PHASE_RECS = 36;
    localparam int PHASES     = 11;

    localparam logic [rsr_pkg::CFG_W-1:0] PHASE_SLOTS [PHASES] = '{
        5'd16, 5'd1, 5'd2, 5'd0, 5'd31, 5'd17, 5'd3, 5'd5, 5'd8, 5'd4, 5'd16
    };

    typedef struct packed {
        logic [rsr_pkg::KEY_W-1:0] key;
        logic [rsr_pkg::TAG_W-1:0] tag;
        logic                      last;
    } t_record;

    typedef struct packed {
        logic [rsr_pkg::KEY_W-1:0] key;
        logic [rsr_pkg::TAG_W-1:0] tag;
        logic [rsr_pkg::RUN_W-1:0] run;
        logic                      done;
    } t_emitted;

    typedef enum {KEYS_ANY, KEYS_NARROW, KEYS_RISING, KEYS_FALLING} t_key_shape;

    logic i_clk;
    logic i_rst_n;

    rsr_cfg_if cfg_bus ();
    rsr_in_if  rec_bus ();
    rsr_out_if res_bus ();

    replacement_selection_runs_unit #(.SLOTS(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_rec   (rec_bus),
        .o_res   (res_bus)
    );

    logic [rsr_pkg::KEY_W-1:0] slot_key  [SLOTS];
    logic [rsr_pkg::TAG_W-1:0] slot_tag  [SLOTS];
    bit                        slot_held [SLOTS];
    bit                        slot_cold [SLOTS];
    int                        filled;
    logic [rsr_pkg::RUN_W-1:0] run_no;
    logic [rsr_pkg::CFG_W-1:0] slot_reg;

    t_record  pending_recs [$];
    t_emitted due_results  [$];

    bit rec_live     = 1'b0;
    bit res_hold_req = 1'b0;
    bit idle_on      = 1'b1;
    int rec_gap      = 0;
    int res_gap      = 0;
    int hold_left    = 0;
    int quiet        = 0;
    int fails        = 0;

    function automatic int active_slots();
        if (slot_reg == '0) return 1;
        if (slot_reg > SLOTS) return SLOTS;
        return int'(slot_reg);
    endfunction

    function automatic void empty_slots();
        for (int i = 0; i < SLOTS; i++) begin
            slot_held[i] = 1'b0;
            slot_cold[i] = 1'b0;
        end
        filled = 0;
        run_no = '0;
    endfunction

    function automatic void thaw_when_all_frozen();
        bit any_held;
        bit any_live;
        any_held = 1'b0;
        any_live = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_held[i]) begin
                any_held = 1'b1;
                if (!slot_cold[i]) any_live = 1'b1;
            end
        end
        if (any_held && !any_live) begin
            run_no = run_no + 1'b1;
            for (int i = 0; i < SLOTS; i++) slot_cold[i] = 1'b0;
        end
    endfunction

    function automatic int least_live_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_held[i] && !slot_cold[i] && (best < 0 || slot_key[i] < slot_key[best]))
                best = i;
        end
        return best;
    endfunction

    function automatic void emit_slot(int s);
        t_emitted e;
        e.key  = slot_key[s];
        e.tag  = slot_tag[s];
        e.run  = run_no;
        e.done = 1'b0;
        due_results.push_back(e);
    endfunction

    function automatic void predict_runs(t_record r);
        int                        s;
        int                        first;
        logic [rsr_pkg::KEY_W-1:0] gone;
        first = due_results.size();
        if (filled < active_slots()) begin
            s = filled;
            slot_key[s]  = r.key;
            slot_tag[s]  = r.tag;
            slot_held[s] = 1'b1;
            slot_cold[s] = 1'b0;
            filled++;
        end else begin
            thaw_when_all_frozen();
            s = least_live_slot();
            if (s < 0) s = 0;
            gone = slot_key[s];
            emit_slot(s);
            slot_key[s]  = r.key;
            slot_tag[s]  = r.tag;
            slot_held[s] = 1'b1;
            slot_cold[s] = r.key < gone;
            thaw_when_all_frozen();
        end
        if (r.last) begin
            while (1) begin
                thaw_when_all_frozen();
                s = least_live_slot();
                if (s < 0) break;
                emit_slot(s);
                slot_held[s] = 1'b0;
                slot_cold[s] = 1'b0;
            end
            if (due_results.size() > first) due_results[due_results.size() - 1].done = 1'b1;
            empty_slots();
        end
    endfunction

    function automatic void flag_fail(string what, logic [63:0] want, logic [63:0] got);
        fails++;
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
    endfunction

    function automatic void queue_record(logic [rsr_pkg::KEY_W-1:0] k,
                                         logic [rsr_pkg::TAG_W-1:0] t, logic l);
        t_record r;
        r.key  = k;
        r.tag  = t;
        r.last = l;
        pending_recs.push_back(r);
    endfunction

    task automatic queue_stream(int len, bit closed);
        t_key_shape                shape;
        logic [rsr_pkg::KEY_W-1:0] cur;
        logic [rsr_pkg::KEY_W-1:0] k;
        shape = t_key_shape'($urandom_range(0, 3));
        cur   = $urandom;
        for (int i = 0; i < len; i++) begin
            case (shape)
                KEYS_ANY: begin
                    k = $urandom;
                end
                KEYS_NARROW: begin
                    k = $urandom_range(0, 7);
                end
                KEYS_RISING: begin
                    cur = cur + $urandom_range(0, 999);
                    k   = cur;
                end
                default: begin
                    cur = cur - $urandom_range(0, 999);
                    k   = cur;
                end
            endcase
            queue_record(k, rsr_pkg::TAG_W'($urandom_range(0, 16'hFFFF)),
                         closed && i == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_recs.size() != 0 || rec_live || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_slots(logic [rsr_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        cfg_bus.slots_in_use <= v;
        cfg_bus.valid        <= 1'b1;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        slot_reg = v;
        empty_slots();
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin : record_driver
        if (!i_rst_n) begin
            rec_bus.valid        <= 1'b0;
            rec_bus.record_key   <= '0;
            rec_bus.record_tag   <= '0;
            rec_bus.final_record <= 1'b0;
        end else if (!rec_live) begin
            if (rec_gap > 0) begin
                rec_gap--;
                rec_bus.valid <= 1'b0;
            end else if (pending_recs.size() != 0) begin
                rec_bus.record_key   <= pending_recs[0].key;
                rec_bus.record_tag   <= pending_recs[0].tag;
                rec_bus.final_record <= pending_recs[0].last;
                rec_bus.valid        <= 1'b1;
                rec_live = 1'b1;
            end else begin
                rec_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_receiver
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_hold_req) begin
                hold_left    = HOLD;
                res_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (res_gap > 0) begin
                res_gap--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_record  took;
        t_emitted seen;
        t_emitted want;
        if (i_rst_n) begin
            if (rec_bus.valid && rec_bus.ready) begin
                took.key  = rec_bus.record_key;
                took.tag  = rec_bus.record_tag;
                took.last = rec_bus.final_record;
                void'(pending_recs.pop_front());
                predict_runs(took);
                rec_live = 1'b0;
                rec_gap  = idle_on ? $urandom_range(0, 8) : 0;
            end
            if (res_bus.valid && res_bus.ready) begin
                seen.key  = res_bus.out_key;
                seen.tag  = res_bus.out_tag;
                seen.run  = res_bus.run_index;
                seen.done = res_bus.stream_done;
                res_gap   = idle_on ? $urandom_range(0, 8) : 0;
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t ns: unexpected result, expected none actual %h/%h/%h/%b",
                             $time, seen.key, seen.tag, seen.run, seen.done);
                end else begin
                    want = due_results.pop_front();
                    if (seen.key !== want.key)
                        flag_fail("out_key", 64'(want.key), 64'(seen.key));
                    if (seen.tag !== want.tag)
                        flag_fail("out_tag", 64'(want.tag), 64'(seen.tag));
                    if (seen.run !== want.run)
                        flag_fail("run_index", 64'(want.run), 64'(seen.run));
                    if (seen.done !== want.done)
                        flag_fail("stream_done", 64'(want.done), 64'(seen.done));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (rec_bus.valid && rec_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int m;
        int left;
        int len;
        i_rst_n              = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.slots_in_use = rsr_pkg::CFG_RESET;
        slot_reg             = rsr_pkg::CFG_RESET;
        empty_slots();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ties, key extremes, freezing and a last record after the slots fill
        write_slots(5'd3);
        queue_record(32'h0000_0000, 16'h0000, 1'b0);
        queue_record(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        queue_record(32'h8000_0000, 16'h1234, 1'b0);
        queue_record(32'h0000_0005, 16'h0001, 1'b0);
        queue_record(32'h0000_0001, 16'h0002, 1'b0);
        queue_record(32'h0000_0001, 16'h0003, 1'b0);
        queue_record(32'hFFFF_FFFF, 16'h0004, 1'b0);
        queue_record(32'h0000_0007, 16'h0005, 1'b1);
        // last record while still filling, and as the very first record
        queue_record(32'h0000_0009, 16'h0006, 1'b0);
        queue_record(32'h0000_0009, 16'h0007, 1'b1);
        queue_record(32'hAAAA_5555, 16'hFFFF, 1'b1);
        wait_drained();

        // falling keys with one slot: a new run per record
        write_slots(5'd1);
        queue_record(32'd100, 16'hFFFF, 1'b0);
        queue_record(32'd90,  16'h0000, 1'b0);
        queue_record(32'd80,  16'h5A5A, 1'b0);
        queue_record(32'd70,  16'hA5A5, 1'b0);
        queue_record(32'd60,  16'h0F0F, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_slots(PHASE_SLOTS[p]);
            idle_on = (p % 4 != 2);
            if (p == 0) res_hold_req = 1'b1;
            m    = active_slots();
            left = PHASE_RECS;
            while (left > 0) begin
                len = $urandom_range(1, 3 * m + 2);
                if (len > left) len = left;
                queue_stream(len, $urandom_range(0, 7) != 0);
                left -= len;
                if (p == 5) wait_drained();
            end
            wait_drained();
        end

        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rsr_pkg.sv
design/rsr_in_if.sv
design/rsr_out_if.sv
design/rsr_cfg_if.sv
design/replacement_selection_runs_unit.sv
sim/tb_top.sv
